FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the compositor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/eec_pkg.sv
// ----------------------------------------------------------------------------
// eec_pkg
// Shared constants, codes and types of the eased effect compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package eec_pkg;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// effect kinds
	localparam logic [3:0] FX_FADEIN   = 4'd0;
	localparam logic [3:0] FX_FADEOUT  = 4'd1;
	localparam logic [3:0] FX_SLIDEL   = 4'd2;
	localparam logic [3:0] FX_SLIDER   = 4'd3;
	localparam logic [3:0] FX_ZOOMIN   = 4'd4;
	localparam logic [3:0] FX_ZOOMOUT  = 4'd5;
	localparam logic [3:0] FX_COLOR    = 4'd6;

	// curve kinds
	localparam logic [2:0] CV_EASEIN    = 3'd1;
	localparam logic [2:0] CV_EASEINOUT = 3'd3;
	localparam logic [2:0] CV_CUSTOM    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_Y0      = 3'd0;
	localparam logic [2:0] REG_Y1      = 3'd1;
	localparam logic [2:0] REG_Y2      = 3'd2;
	localparam logic [2:0] REG_Y3      = 3'd3;
	localparam logic [2:0] REG_PRESENT = 3'd4;

	typedef struct packed {
		logic        done;
		logic [16:0] p;
	} prog_t;

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -67'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/eased_effect_compositor.sv
// ----------------------------------------------------------------------------
// eased_effect_compositor
// Folds eased clip effects into composite opacity, offset, scale and colour.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_*       in   tuser: first, kind, curve; tlast: last; tdata: times, amounts, rgb
//  m_*       out  tdata: opacity, offset, scale, red, green, blue
//  cfg_*     in   curve control points and custom-present flag
//
//  from one request to the next an item takes these steps, plus any output stall:
//  the progress, dividing for the quotient (one bit a cycle) when it is needed;
//  multiplies on the shared 34x33 multiplier, product then result (preset curve two,
//  custom curve ten plus a clamp, fade and slide one, zoom two, colour three),
//  then finish, a result held on the output when the item is last, and idle
//  s_tready is high only while idle; a result holds on m_tdata until taken
//  asynchronous reset loads identity accumulators and the default curve
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module eased_effect_compositor import eec_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// time_now, effect_start, effect_length, amount_a, amount_b, target_rgb, base_rgb
	input  wire logic [207:0] s_tdata,
	// first_effect, effect_kind, curve_kind
	input  wire logic [7:0]   s_tuser,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_opacity, out_offset_x, out_scale, out_red, out_green, out_blue, zero fill
	output logic [111:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [17:0]  cfg_wdata
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DIV   = 5'd1;
	localparam logic [4:0] S_EP2   = 5'd2;
	localparam logic [4:0] S_EPRE  = 5'd3;
	localparam logic [4:0] S_CU2   = 5'd4;
	localparam logic [4:0] S_CP2   = 5'd5;
	localparam logic [4:0] S_CU3   = 5'd6;
	localparam logic [4:0] S_CW1   = 5'd7;
	localparam logic [4:0] S_CW2   = 5'd8;
	localparam logic [4:0] S_CW3   = 5'd9;
	localparam logic [4:0] S_CY0   = 5'd10;
	localparam logic [4:0] S_CY1   = 5'd11;
	localparam logic [4:0] S_CY2   = 5'd12;
	localparam logic [4:0] S_CY3   = 5'd13;
	localparam logic [4:0] S_CYF   = 5'd14;
	localparam logic [4:0] S_FADE  = 5'd15;
	localparam logic [4:0] S_SLIDE = 5'd16;
	localparam logic [4:0] S_Z1    = 5'd17;
	localparam logic [4:0] S_Z2    = 5'd18;
	localparam logic [4:0] S_K0    = 5'd19;
	localparam logic [4:0] S_K1    = 5'd20;
	localparam logic [4:0] S_K2    = 5'd21;
	localparam logic [4:0] S_FIN   = 5'd22;
	localparam logic [4:0] S_OUT   = 5'd23;

	logic [4:0]  state_q;
	logic        ph_q;

	logic signed [17:0] cy_q [4];
	logic               present_q;

	logic [16:0]        acc_opacity_q;
	logic signed [31:0] acc_offset_q;
	logic signed [31:0] acc_scale_q;
	logic [23:0]        acc_color_q;

	logic               last_q;
	logic [3:0]         kind_q;
	logic [2:0]         curve_q;
	logic signed [31:0] amt_a_q;
	logic signed [31:0] amt_b_q;
	logic [23:0]        tgt_q;

	logic [16:0]        p_q;
	logic [16:0]        e_q;
	logic [33:0]        t0_q;
	logic [33:0]        t1_q;
	logic [32:0]        w_q [4];
	logic signed [55:0] yacc_q;
	logic signed [31:0] z_q;
	logic signed [66:0] prod_q;

	prog_t              prog;
	logic               accept;
	logic               is_mul;
	logic [1:0]         ysel;
	logic [1:0]         csel;
	logic [16:0]        u_c;
	logic [16:0]        inv_e;
	logic [16:0]        fade_f;
	logic [16:0]        zoom_w;
	logic signed [32:0] b_minus_a;
	logic [17:0]        pre_k;
	logic [7:0]         chan_c;
	logic [7:0]         chan_t;
	logic signed [8:0]  diff;
	logic signed [33:0] op_a;
	logic signed [32:0] op_b;

	logic signed [66:0] rnd16;
	logic signed [66:0] flr16;
	logic signed [66:0] trip;
	logic signed [66:0] pre_e;
	logic signed [66:0] slide_sum;
	logic signed [66:0] zoom_sum;
	logic signed [66:0] chan_sum;
	logic [7:0]         chan_new;
	logic signed [55:0] yv;
	logic [16:0]        y_clamped;

	function automatic logic [4:0] effect_entry(input logic [3:0] kind);
		logic [4:0] s;
		if (kind == FX_FADEIN || kind == FX_FADEOUT) begin
			s = S_FADE;
		end else if (kind == FX_SLIDEL || kind == FX_SLIDER) begin
			s = S_SLIDE;
		end else if (kind == FX_ZOOMIN || kind == FX_ZOOMOUT) begin
			s = S_Z1;
		end else if (kind == FX_COLOR) begin
			s = S_K0;
		end else begin
			s = S_FIN;
		end
		return s;
	endfunction

	eec_progress u_prog (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.t_now   (s_tdata[31:0]),
		.t_start (s_tdata[63:32]),
		.t_len   (s_tdata[95:64]),
		.res     (prog)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {7'd0, acc_color_q[7:0], acc_color_q[15:8], acc_color_q[23:16],
		acc_scale_q, acc_offset_q, acc_opacity_q};

	assign is_mul = (state_q >= S_EP2 && state_q <= S_CY3) ||
		(state_q >= S_FADE && state_q <= S_K2);
	assign ysel = 2'(state_q - S_CY0);
	assign csel = 2'(state_q - S_K0);

	assign u_c       = ONE_Q16 - p_q;
	assign inv_e     = ONE_Q16 - e_q;
	assign fade_f    = (kind_q == FX_FADEIN) ? e_q : inv_e;
	assign zoom_w    = (kind_q == FX_ZOOMIN) ? e_q : inv_e;
	assign b_minus_a = {amt_b_q[31], amt_b_q} - {amt_a_q[31], amt_a_q};
	assign pre_k     = 18'd196608 - {p_q, 1'b0};

	always_comb begin
		unique case (csel)
			2'd0: begin
				chan_c = acc_color_q[23:16];
				chan_t = tgt_q[23:16];
			end
			2'd1: begin
				chan_c = acc_color_q[15:8];
				chan_t = tgt_q[15:8];
			end
			default: begin
				chan_c = acc_color_q[7:0];
				chan_t = tgt_q[7:0];
			end
		endcase
	end
	assign diff = $signed({1'b0, chan_t}) - $signed({1'b0, chan_c});

	// operand selection for the shared multiplier
	always_comb begin
		op_a = 34'sd0;
		op_b = 33'sd0;
		unique case (state_q)
			S_EP2, S_CP2: begin
				op_a = $signed({17'd0, p_q});
				op_b = $signed({16'd0, p_q});
			end
			S_EPRE: begin
				op_a = $signed(t0_q);
				op_b = $signed({15'd0, pre_k});
			end
			S_CU2: begin
				op_a = $signed({17'd0, u_c});
				op_b = $signed({16'd0, u_c});
			end
			S_CU3: begin
				op_a = $signed(t0_q);
				op_b = $signed({16'd0, u_c});
			end
			S_CW1: begin
				op_a = $signed(t0_q);
				op_b = $signed({16'd0, p_q});
			end
			S_CW2: begin
				op_a = $signed(t1_q);
				op_b = $signed({16'd0, u_c});
			end
			S_CW3: begin
				op_a = $signed(t1_q);
				op_b = $signed({16'd0, p_q});
			end
			S_CY0, S_CY1, S_CY2, S_CY3: begin
				op_a = $signed({1'b0, w_q[ysel]});
				op_b = 33'(cy_q[ysel]);
			end
			S_FADE: begin
				op_a = $signed({17'd0, acc_opacity_q});
				op_b = $signed({16'd0, fade_f});
			end
			S_SLIDE: begin
				op_a = 34'(amt_a_q);
				op_b = $signed({16'd0, inv_e});
			end
			S_Z1: begin
				op_a = 34'(b_minus_a);
				op_b = $signed({16'd0, zoom_w});
			end
			S_Z2: begin
				op_a = 34'(acc_scale_q);
				op_b = 33'(z_q);
			end
			S_K0, S_K1, S_K2: begin
				op_a = $signed({17'd0, e_q});
				op_b = 33'(diff);
			end
			default: begin
				op_a = 34'sd0;
				op_b = 33'sd0;
			end
		endcase
	end

	assign rnd16 = (prod_q + 67'sd32768) >>> 16;
	assign flr16 = prod_q >>> 16;
	assign trip  = prod_q + (prod_q <<< 1);
	assign pre_e = (prod_q + 67'sd2147483648) >>> 32;

	assign slide_sum = (kind_q == FX_SLIDEL) ? (67'(acc_offset_q) - rnd16)
		: (67'(acc_offset_q) + rnd16);
	assign zoom_sum  = 67'(amt_a_q) + rnd16;
	assign chan_sum  = $signed({59'd0, chan_c}) + flr16;

	always_comb begin
		if (chan_sum < 67'sd0) begin
			chan_new = 8'd0;
		end else if (chan_sum > 67'sd255) begin
			chan_new = 8'd255;
		end else begin
			chan_new = chan_sum[7:0];
		end
	end

	assign yv = (yacc_q + 56'sd2147483648) >>> 32;
	always_comb begin
		if (yv < 56'sd0) begin
			y_clamped = 17'd0;
		end else if (yv > 56'sd65536) begin
			y_clamped = ONE_Q16;
		end else begin
			y_clamped = yv[16:0];
		end
	end

	// sequencer, configuration and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ph_q          <= 1'b0;
			cy_q[0]       <= 18'sd0;
			cy_q[1]       <= 18'sd0;
			cy_q[2]       <= 18'sd65536;
			cy_q[3]       <= 18'sd65536;
			present_q     <= 1'b0;
			acc_opacity_q <= ONE_Q16;
			acc_offset_q  <= 32'sd0;
			acc_scale_q   <= 32'sd65536;
			acc_color_q   <= 24'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_Y0:      cy_q[0] <= cfg_wdata;
					REG_Y1:      cy_q[1] <= cfg_wdata;
					REG_Y2:      cy_q[2] <= cfg_wdata;
					REG_Y3:      cy_q[3] <= cfg_wdata;
					REG_PRESENT: present_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			if (is_mul) begin
				ph_q <= !ph_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser[0]) begin
							acc_opacity_q <= ONE_Q16;
							acc_offset_q  <= 32'sd0;
							acc_scale_q   <= 32'sd65536;
							acc_color_q   <= s_tdata[207:184];
						end
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (prog.done) begin
						if (curve_q >= CV_EASEIN && curve_q <= CV_EASEINOUT) begin
							state_q <= S_EP2;
						end else if (curve_q == CV_CUSTOM && present_q) begin
							state_q <= S_CU2;
						end else begin
							state_q <= effect_entry(kind_q);
						end
					end
				end
				S_CYF: state_q <= effect_entry(kind_q);
				S_FIN: state_q <= last_q ? S_OUT : S_IDLE;
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (ph_q) begin
						priority case (state_q)
							S_EPRE:  state_q <= effect_entry(kind_q);
							S_FADE: begin
								acc_opacity_q <= rnd16[16:0];
								state_q       <= S_FIN;
							end
							S_SLIDE: begin
								acc_offset_q <= sat32(slide_sum);
								state_q      <= S_FIN;
							end
							S_Z2: begin
								acc_scale_q <= sat32(rnd16);
								state_q     <= S_FIN;
							end
							S_K0: begin
								acc_color_q[23:16] <= chan_new;
								state_q            <= S_K1;
							end
							S_K1: begin
								acc_color_q[15:8] <= chan_new;
								state_q           <= S_K2;
							end
							S_K2: begin
								acc_color_q[7:0] <= chan_new;
								state_q          <= S_FIN;
							end
							default: state_q <= state_q + 5'd1;
						endcase
					end
				end
			endcase
		end
	end

	// item fields and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q  <= s_tlast;
			kind_q  <= s_tuser[4:1];
			curve_q <= s_tuser[7:5];
			amt_a_q <= s_tdata[127:96];
			amt_b_q <= s_tdata[159:128];
			tgt_q   <= s_tdata[183:160];
		end
		if (state_q == S_DIV && prog.done) begin
			p_q <= prog.p;
			e_q <= prog.p;
		end
		if (state_q == S_CYF) begin
			e_q <= y_clamped;
		end
		if (is_mul && !ph_q) begin
			prod_q <= op_a * op_b;
		end
		if (is_mul && ph_q) begin
			unique case (state_q)
				S_EP2:  t0_q   <= prod_q[33:0];
				S_EPRE: e_q    <= pre_e[16:0];
				S_CU2:  t0_q   <= prod_q[33:0];
				S_CP2:  t1_q   <= prod_q[33:0];
				S_CU3:  w_q[0] <= flr16[32:0];
				S_CW1:  w_q[1] <= 33'(trip >>> 16);
				S_CW2:  w_q[2] <= 33'(trip >>> 16);
				S_CW3:  w_q[3] <= flr16[32:0];
				S_CY0:  yacc_q <= prod_q[55:0];
				S_CY1, S_CY2, S_CY3: yacc_q <= yacc_q + prod_q[55:0];
				S_Z1:   z_q    <= sat32(zoom_sum);
				default: begin
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_IMPLIES(a_opacity_range, clk, arst_n, m_tvalid, acc_opacity_q <= ONE_Q16)
	`ASSERT_IMPLIES(a_div_done_waited, clk, arst_n, prog.done, state_q == S_DIV)

endmodule

`default_nettype wire

FILE: sv/eec_progress.sv
// ----------------------------------------------------------------------------
// eec_progress
// Progress in Q1.16 from time, start and length; restoring divider, one
// quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_progress import eec_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] t_now,
	input  wire logic [31:0] t_start,
	input  wire logic [31:0] t_len,
	output prog_t            res
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] len_q;
	logic [15:0] quo_q;
	logic [16:0] p_q;

	logic [31:0] d;
	logic [32:0] r2;
	logic        ge;
	logic [31:0] rnext;

	assign d     = t_now - t_start;
	assign r2    = {rem_q, 1'b0};
	assign ge    = r2 >= {1'b0, len_q};
	assign rnext = ge ? 32'(r2 - {1'b0, len_q}) : r2[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				if (t_len == 32'd0 || t_now <= t_start || d >= t_len) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'd16;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= d;
			len_q <= t_len;
			quo_q <= 16'd0;
			// zero length or past the end is complete, before start is zero
			if (t_len == 32'd0) begin
				p_q <= ONE_Q16;
			end else if (t_now <= t_start) begin
				p_q <= 17'd0;
			end else if (d >= t_len) begin
				p_q <= ONE_Q16;
			end
		end else if (busy_q) begin
			rem_q <= rnext;
			quo_q <= {quo_q[14:0], ge};
			if (cnt_q == 5'd1) begin
				p_q <= {1'b0, quo_q[14:0], ge};
			end
		end
	end

	assign res.done = done_q;
	assign res.p    = p_q;

endmodule

`default_nettype wire

FILE: dv/tb_eased_effect_compositor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eased_effect_compositor
// Drives clips of eased effects through the compositor and checks each
// composite against a typed expectation or a local fixed-point predictor,
// across several curve settings and with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_eased_effect_compositor;
	import eec_pkg::*;

	localparam logic [3:0] FX_BLUR      = 4'd7;
	localparam logic [3:0] FX_PASS      = 4'd8;
	localparam logic [2:0] CV_LINEAR    = 3'd0;
	localparam logic [2:0] CV_EASEOUT   = 3'd2;
	localparam int         SETTLE       = 80;
	localparam int         STALL_LIMIT  = 20000;
	localparam int         PHASE_ITEMS  = 280;
	localparam longint     Q1           = 65536;

	typedef struct packed {
		logic [16:0] opacity;
		logic [31:0] offset;
		logic [31:0] scale;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} composite_t;

	typedef struct {
		bit          fx_first;
		bit          fx_last;
		logic [3:0]  kind;
		logic [2:0]  curve;
		logic [31:0] t_now;
		logic [31:0] t_start;
		logic [31:0] t_len;
		logic [31:0] amt_a;
		logic [31:0] amt_b;
		logic [23:0] tgt;
		logic [23:0] base;
		bit          typed;
		composite_t  want;
	} effect_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [207:0] s_tdata = '0;
	logic [7:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = REG_Y0;
	logic [17:0]  cfg_wdata = '0;

	// curve registers and running composite of the predictor
	longint     cy [4];
	bit         cpresent;
	longint     acc_op, acc_off, acc_sc;
	logic [23:0] acc_rgb;

	composite_t composite_q [$];
	int         errors = 0;
	int         results_seen = 0;
	int         items_sent = 0;
	int         idle_mode = 0;
	int         quiet_cycles = 0;

	always #5 clk = ~clk;

	eased_effect_compositor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	function automatic longint sat_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rnd_sh(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint progress_of(input logic [31:0] now, input logic [31:0] st,
			input logic [31:0] len);
		logic [63:0] d;
		if (len == 0) return Q1;
		if (now <= st) return 0;
		d = 64'(now - st);
		if (d >= 64'(len)) return Q1;
		return longint'((d << 16) / 64'(len));
	endfunction

	function automatic longint eased(input logic [2:0] curve, input longint p);
		longint u, y;
		if (curve >= CV_EASEIN && curve <= CV_EASEINOUT)
			return rnd_sh(3 * p * p * Q1 - 2 * p * p * p, 32);
		if (curve == CV_CUSTOM && cpresent) begin
			u = Q1 - p;
			y = rnd_sh(((u * u * u) >>> 16) * cy[0] + ((3 * u * u * p) >>> 16) * cy[1]
				+ ((3 * u * p * p) >>> 16) * cy[2] + ((p * p * p) >>> 16) * cy[3], 32);
			if (y < 0) y = 0;
			if (y > Q1) y = Q1;
			return y;
		end
		return p;
	endfunction

	function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] t,
			input longint e);
		longint r;
		r = longint'(c) + ((e * (longint'(t) - longint'(c))) >>> 16);
		if (r < 0) r = 0;
		if (r > 255) r = 255;
		return r[7:0];
	endfunction

	// updates the running composite and queues the composite a last item yields
	task automatic fold_effect(input effect_t it);
		longint e, f, o, z, a, b;
		composite_t c;
		a = longint'($signed(it.amt_a));
		b = longint'($signed(it.amt_b));
		if (it.fx_first) begin
			acc_op = Q1;
			acc_off = 0;
			acc_sc = Q1;
			acc_rgb = it.base;
		end
		e = eased(it.curve, progress_of(it.t_now, it.t_start, it.t_len));
		case (it.kind)
			FX_FADEIN, FX_FADEOUT: begin
				f = (it.kind == FX_FADEIN) ? e : Q1 - e;
				acc_op = rnd_sh(acc_op * f, 16);
			end
			FX_SLIDEL, FX_SLIDER: begin
				o = rnd_sh(a * (Q1 - e), 16);
				acc_off = sat_s32(acc_off + ((it.kind == FX_SLIDEL) ? -o : o));
			end
			FX_ZOOMIN, FX_ZOOMOUT: begin
				f = (it.kind == FX_ZOOMIN) ? e : Q1 - e;
				z = sat_s32(a + rnd_sh(f * (b - a), 16));
				acc_sc = sat_s32(rnd_sh(acc_sc * z, 16));
			end
			FX_COLOR: begin
				acc_rgb = {blend(acc_rgb[23:16], it.tgt[23:16], e),
					blend(acc_rgb[15:8], it.tgt[15:8], e), blend(acc_rgb[7:0], it.tgt[7:0], e)};
			end
			default: ;
		endcase
		if (it.fx_last) begin
			c.opacity = acc_op[16:0];
			c.offset = acc_off[31:0];
			c.scale = acc_sc[31:0];
			{c.red, c.green, c.blue} = acc_rgb;
			composite_q.push_back(it.typed ? it.want : c);
		end
	endtask

	function automatic effect_t mk(input bit fst, input bit lst, input logic [3:0] kind,
			input logic [2:0] curve, input logic [31:0] now, input logic [31:0] st,
			input logic [31:0] len, input logic [31:0] a, input logic [31:0] b,
			input logic [23:0] tgt, input logic [23:0] base);
		effect_t it;
		it = '{fst, lst, kind, curve, now, st, len, a, b, tgt, base, 1'b0, '0};
		return it;
	endfunction

	function automatic effect_t typed_row(input effect_t it, input logic [16:0] op,
			input logic [31:0] off, input logic [31:0] sc, input logic [23:0] rgb);
		it.typed = 1'b1;
		it.want = '{op, off, sc, rgb[23:16], rgb[15:8], rgb[7:0]};
		return it;
	endfunction

	function automatic logic [31:0] rnd_time_word();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'hffffffff - $urandom_range(0, 3);
			default: return $urandom_range(0, 100000);
		endcase
	endfunction

	function automatic logic [31:0] rnd_amount();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'(-$signed(32'($urandom_range(0, 32'h0020_0000))));
			default: return $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	// mostly well-formed clips of meaningful timing, some noise on the flags
	function automatic effect_t rnd_effect(input bit fst, input bit lst);
		effect_t it;
		logic [31:0] st, len;
		st = rnd_time_word();
		len = ($urandom_range(0, 9) == 0) ? 32'd0 :
			($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 5000);
		it = mk(fst, lst, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) :
			4'($urandom_range(0, 8)), 3'($urandom_range(0, 7)),
			($urandom_range(0, 7) == 0) ? $urandom() :
			st + 32'($urandom_range(0, len > 100000 ? 100000 : len + 100)) - 32'd50,
			st, len, rnd_amount(), rnd_amount(), 24'($urandom()), 24'($urandom()));
		if ($urandom_range(0, 19) == 0) it.fx_first = ~it.fx_first;
		if ($urandom_range(0, 19) == 0) it.fx_last = ~it.fx_last;
		return it;
	endfunction

	task automatic sender_gap();
		int pct;
		pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 19 : 0;
		while ($urandom_range(0, 99) < pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_effect(input effect_t it);
		sender_gap();
		s_tvalid <= 1'b1;
		s_tdata <= {it.base, it.tgt, it.amt_b, it.amt_a, it.t_len, it.t_start, it.t_now};
		s_tuser <= {it.curve, it.kind, it.fx_first};
		s_tlast <= it.fx_last;
		do @(posedge clk); while (!s_tready);
		fold_effect(it);
		items_sent++;
	endtask

	// hold off until every composite is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (composite_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_PRESENT) cpresent = val[0];
		else cy[idx] = longint'($signed(val));
	endtask

	task automatic set_curve(input logic [17:0] y0, input logic [17:0] y1,
			input logic [17:0] y2, input logic [17:0] y3, input bit present);
		write_reg(REG_Y0, y0);
		write_reg(REG_Y1, y1);
		write_reg(REG_Y2, y2);
		write_reg(REG_Y3, y3);
		write_reg(REG_PRESENT, 18'(present));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		case (idle_mode)
			2:       m_tready <= ($urandom_range(0, 99) >= 80);
			3:       m_tready <= ($urandom_range(0, 99) >= 19);
			default: m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		composite_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.opacity = m_tdata[16:0];
			got.offset  = m_tdata[48:17];
			got.scale   = m_tdata[80:49];
			got.red     = m_tdata[88:81];
			got.green   = m_tdata[96:89];
			got.blue    = m_tdata[104:97];
			results_seen++;
			if (composite_q.size() == 0) begin
				$display("%0t: composite with none expected, actual %h", $time, got);
				errors++;
			end else begin
				want = composite_q.pop_front();
				if (got != want) begin
					$display("%0t: composite mismatch expected op=%h off=%h sc=%h rgb=%h%h%h",
						$time, want.opacity, want.offset, want.scale,
						want.red, want.green, want.blue);
					$display("%0t:                      actual op=%h off=%h sc=%h rgb=%h%h%h",
						$time, got.opacity, got.offset, got.scale,
						got.red, got.green, got.blue);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		effect_t table_rows [$];
		int n;
		cy = '{0, 0, Q1, Q1};
		cpresent = 1'b0;
		acc_op = Q1;
		acc_off = 0;
		acc_sc = Q1;
		acc_rgb = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed clips under the reset curve
		table_rows.push_back(typed_row(mk(0, 1, FX_PASS, CV_LINEAR, 0, 0, 0, 0, 0, 0, 0),
			17'd65536, 32'd0, 32'd65536, 24'h000000));
		table_rows.push_back(typed_row(mk(1, 1, FX_BLUR, CV_LINEAR, 5, 1, 9, 1, 2, 0,
			24'habcdef), 17'd65536, 32'd0, 32'd65536, 24'habcdef));
		table_rows.push_back(typed_row(mk(1, 1, FX_FADEIN, CV_EASEINOUT, 7, 3, 0, 0, 0, 0,
			24'hffffff), 17'd65536, 32'd0, 32'd65536, 24'hffffff));
		table_rows.push_back(typed_row(mk(1, 1, FX_FADEOUT, CV_EASEIN, 7, 3, 0, 0, 0, 0, 0),
			17'd0, 32'd0, 32'd65536, 24'h000000));
		table_rows.push_back(typed_row(mk(1, 1, FX_FADEIN, CV_LINEAR, 2, 9, 100, 0, 0, 0, 0),
			17'd0, 32'd0, 32'd65536, 24'h000000));
		table_rows.push_back(typed_row(mk(1, 1, FX_SLIDEL, CV_LINEAR, 0, 32'hffffffff,
			32'hffffffff, 32'h7fffffff, 0, 0, 0), 17'd65536, 32'h80000001, 32'd65536, 24'h0));
		table_rows.push_back(typed_row(mk(1, 1, FX_SLIDER, CV_EASEOUT, 9, 0, 0, 32'h80000000,
			0, 0, 0), 17'd65536, 32'd0, 32'd65536, 24'h0));
		table_rows.push_back(typed_row(mk(1, 1, FX_ZOOMIN, CV_LINEAR, 1, 1, 0, 32'h80000000,
			32'h7fffffff, 0, 0), 17'd65536, 32'd0, 32'h7fffffff, 24'h0));
		table_rows.push_back(typed_row(mk(1, 1, FX_COLOR, CV_CUSTOM, 1, 1, 0, 0, 0,
			24'h123456, 24'h000000), 17'd65536, 32'd0, 32'd65536, 24'h123456));
		// a mid-progress clip folding every kind, checked by the predictor
		table_rows.push_back(mk(1, 0, FX_FADEIN, CV_LINEAR, 150, 100, 200, 0, 0, 0, 24'h808080));
		table_rows.push_back(mk(0, 0, FX_FADEOUT, CV_EASEIN, 130, 100, 200, 0, 0, 0, 0));
		table_rows.push_back(mk(0, 0, FX_SLIDEL, CV_EASEOUT, 170, 100, 200, 32'h00640000, 0, 0, 0));
		table_rows.push_back(mk(0, 0, FX_SLIDER, CV_EASEINOUT, 299, 100, 200, 32'h7fffffff,
			0, 0, 0));
		table_rows.push_back(mk(0, 0, FX_ZOOMIN, CV_CUSTOM, 120, 100, 200, 32'h00010000,
			32'h00030000, 0, 0));
		table_rows.push_back(mk(0, 0, FX_ZOOMOUT, 3'd5, 250, 100, 200, 32'h00008000,
			32'hfffe0000, 0, 0));
		table_rows.push_back(mk(0, 0, FX_COLOR, 3'd6, 200, 100, 200, 0, 0, 24'hff00ff, 0));
		table_rows.push_back(mk(0, 0, 4'd15, 3'd7, 0, 0, 0, 32'h7fffffff, 0, 0, 0));
		table_rows.push_back(mk(0, 1, FX_COLOR, CV_EASEINOUT, 32'hffffffff, 0, 32'hffffffff,
			0, 0, 24'h00ff00, 0));
		// no first item: fold into what is left over
		table_rows.push_back(mk(0, 1, FX_ZOOMOUT, CV_LINEAR, 0, 32'hffffffff, 1,
			32'h7fffffff, 32'h80000000, 0, 0));
		table_rows.push_back(mk(0, 1, 4'd9, CV_LINEAR, 0, 0, 0, 0, 0, 0, 0));
		foreach (table_rows[i]) send_effect(table_rows[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: set_curve(18'($urandom()), 18'($urandom()), 18'($urandom()),
					18'($urandom()), 1'b1);
				2: set_curve(18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff, 1'b1);
				3: set_curve(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000, 1'b0);
				4: set_curve(18'h00000, 18'h08000, 18'h18000, 18'h10000, 1'b1);
				default: ;
			endcase
			idle_mode = (ph == 4) ? 0 : ph;
			n = 0;
			while (n < PHASE_ITEMS) begin
				int clip_len;
				clip_len = $urandom_range(1, 5);
				for (int k = 0; k < clip_len; k++)
					send_effect(rnd_effect(k == 0, k == clip_len - 1));
				n += clip_len;
			end
			drain();
		end

		$display("covered %0d effect items and %0d composites over five curve settings,",
			items_sent, results_seen);
		$display("with sender gaps and receiver stalls mixed in");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/eec_pkg.sv
sv/eec_progress.sv
sv/eased_effect_compositor.sv
dv/tb_eased_effect_compositor.sv
